[src/bfknn_pkg.sv]
// Shared types, constants and register codes for the brute-force k-nearest-neighbor search.
// Used by bfknn_dist, bfknn_sort and the top level; depends on nothing.
package bfknn_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_DIMS   = 16;
    localparam int MAX_K      = 16;

    localparam int PIDX_W  = $clog2(MAX_POINTS);
    localparam int DIDX_W  = $clog2(MAX_DIMS);
    localparam int KIDX_W  = $clog2(MAX_K);
    localparam int ADDR_W  = PIDX_W + DIDX_W;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = 38;

    localparam int NPTS_W  = 11;
    localparam int NDIM_W  = 5;
    localparam int NK_W    = 5;
    localparam int CFG_W   = 11;
    localparam int CFGA_W  = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    typedef enum logic [CFGA_W-1:0] {
        REG_NUM_POINTS    = 2'd0,
        REG_NUM_DIMS      = 2'd1,
        REG_NUM_NEIGHBORS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // One coordinate pair entering the distance unit.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [PIDX_W-1:0] point;
    } issue_t;

    // One finished point distance leaving the distance unit.
    typedef struct packed {
        logic              valid;
        logic [PIDX_W-1:0] point;
        logic [DIST_W-1:0] sq_dist;
    } dist_t;

endpackage

[src/bfknn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bfknn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/bfknn_dist.sv]
// Shared distance unit: subtract, square and accumulate one coordinate per cycle.
// Depends on bfknn_pkg.
module bfknn_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfknn_pkg::issue_t                 issue,
    input  logic signed [bfknn_pkg::COORD_W-1:0] query_value,
    input  logic signed [bfknn_pkg::COORD_W-1:0] ref_value,
    output bfknn_pkg::dist_t                  result,
    output logic                              busy
);

    bfknn_pkg::issue_t                       s2_reg;
    bfknn_pkg::issue_t                       s3_reg;
    logic signed [bfknn_pkg::DIFF_W-1:0]     diff_reg;
    logic signed [bfknn_pkg::SQ_W-1:0]       sq_reg;
    logic [bfknn_pkg::DIST_W-1:0]            acc_reg;
    logic [bfknn_pkg::DIST_W-1:0]            acc_next;
    logic                                    out_valid_reg;
    logic [bfknn_pkg::PIDX_W-1:0]            out_point_reg;
    logic [bfknn_pkg::DIST_W-1:0]            sq_ext;

    assign sq_ext   = bfknn_pkg::DIST_W'(unsigned'(sq_reg));
    assign acc_next = s3_reg.first ? sq_ext : acc_reg + sq_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_reg        <= issue;
            s3_reg        <= s2_reg;
            out_valid_reg <= s3_reg.valid && s3_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= bfknn_pkg::DIFF_W'(query_value) - bfknn_pkg::DIFF_W'(ref_value);
        sq_reg   <= diff_reg * diff_reg;
        if (s3_reg.valid)
        begin
            acc_reg       <= acc_next;
            out_point_reg <= s3_reg.point;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.point   = out_point_reg;
    assign result.sq_dist = acc_reg;
    assign busy           = issue.valid || s2_reg.valid || s3_reg.valid;

endmodule

[src/bfknn_sort.sv]
// Sorted list of the best distances so far; at most one insertion per finished point.
// Depends on bfknn_pkg.
module bfknn_sort (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic [bfknn_pkg::NK_W-1:0]     k_eff,
    input  bfknn_pkg::dist_t               cand,
    input  logic [bfknn_pkg::KIDX_W-1:0]   rd_idx,
    output logic [bfknn_pkg::PIDX_W-1:0]   rd_point,
    output logic [bfknn_pkg::DIST_W-1:0]   rd_dist,
    output logic [bfknn_pkg::KIDX_W:0]     filled
);

    logic [bfknn_pkg::DIST_W-1:0] dist_reg  [bfknn_pkg::MAX_K];
    logic [bfknn_pkg::DIST_W-1:0] dist_next [bfknn_pkg::MAX_K];
    logic [bfknn_pkg::PIDX_W-1:0] idx_reg   [bfknn_pkg::MAX_K];
    logic [bfknn_pkg::PIDX_W-1:0] idx_next  [bfknn_pkg::MAX_K];
    logic [bfknn_pkg::MAX_K-1:0]  le;
    logic [bfknn_pkg::KIDX_W:0]   filled_reg;
    logic [bfknn_pkg::KIDX_W:0]   filled_next;
    logic [bfknn_pkg::KIDX_W:0]   k_ext;
    logic [bfknn_pkg::KIDX_W-1:0] k_last;
    logic                         ins;

    assign k_ext  = (bfknn_pkg::KIDX_W+1)'(k_eff);
    assign k_last = bfknn_pkg::KIDX_W'(k_eff - 1'b1);

    // A cell keeps its entry when it already sorts ahead of the candidate;
    // equal distances stay ahead because they carry lower point indices.
    always_comb
    begin
        for (int j = 0; j < bfknn_pkg::MAX_K; j++)
        begin
            le[j] = ((bfknn_pkg::KIDX_W+1)'(j) < filled_reg) && (dist_reg[j] <= cand.sq_dist);
        end
        ins = cand.valid && !((filled_reg == k_ext) && le[k_last]);
        for (int j = 0; j < bfknn_pkg::MAX_K; j++)
        begin
            dist_next[j] = dist_reg[j];
            idx_next[j]  = idx_reg[j];
            if (ins && !le[j])
            begin
                if (j == 0 || le[(j == 0) ? 0 : j - 1])
                begin
                    dist_next[j] = cand.sq_dist;
                    idx_next[j]  = cand.point;
                end
                else
                begin
                    dist_next[j] = dist_reg[(j == 0) ? 0 : j - 1];
                    idx_next[j]  = idx_reg[(j == 0) ? 0 : j - 1];
                end
            end
        end
        filled_next = filled_reg;
        if (clear)
        begin
            filled_next = '0;
        end
        else if (ins && (filled_reg < k_ext))
        begin
            filled_next = filled_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < bfknn_pkg::MAX_K; j++)
        begin
            dist_reg[j] <= dist_next[j];
            idx_reg[j]  <= idx_next[j];
        end
    end

    assign rd_point = idx_reg[rd_idx];
    assign rd_dist  = dist_reg[rd_idx];
    assign filled   = filled_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= (bfknn_pkg::KIDX_W+1)'(bfknn_pkg::MAX_K))
        else $error("result list overfilled");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> filled_reg == '0)
        else $error("clear did not empty the list");
    a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
        !clear |=> filled_reg == $past(filled_reg) || filled_reg == $past(filled_reg) + 1'b1)
        else $error("list grew by more than one");

endmodule

[src/brute_force_knn_search_top.sv]
// Top level of the brute-force k-nearest-neighbor search: sequencer, query buffer,
// reference store and output stage. Depends on bfknn_pkg, bfknn_ram, bfknn_dist, bfknn_sort.
//
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------------
//  s_*      | in        | tuser: req_type; tdata: point_index, dim_index, coord
//  m_*      | out       | tdata: rank, neighbor_index, squared_distance; tlast
//  cfg_*    | in        | write of num_points, num_dims, num_neighbors
//
// Load and non-final query transactions are accepted while the block is idle. The final
// query coordinate starts a scan over num_points*num_dims coordinate pairs through the
// single distance unit (one coordinate per cycle), followed by a pipeline drain,
// then one result per cycle while the sink is ready. s_tready is low from the scan
// start until the last result is taken. Reset clears control state only; the
// reference store and query buffer are undefined until written.
module brute_force_knn_search_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bfknn_pkg::S_TDATA_W-1:0]     s_tdata,  // point_index, dim_index, coord_value
    input  logic                                s_tuser,  // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bfknn_pkg::M_TDATA_W-1:0]     m_tdata,  // rank, neighbor_index, squared_distance
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [bfknn_pkg::CFGA_W-1:0]        cfg_addr,
    input  logic [bfknn_pkg::CFG_W-1:0]         cfg_wdata
);

    bfknn_pkg::state_t                    state_reg;
    bfknn_pkg::state_t                    state_next;
    logic [bfknn_pkg::NPTS_W-1:0]         npts_reg;
    logic [bfknn_pkg::NDIM_W-1:0]         ndim_reg;
    logic [bfknn_pkg::NK_W-1:0]           nk_reg;
    logic [bfknn_pkg::NPTS_W-1:0]         n_eff;
    logic [bfknn_pkg::NDIM_W-1:0]         m_eff;
    logic [bfknn_pkg::NK_W-1:0]           k_eff;
    logic [bfknn_pkg::PIDX_W-1:0]         p_cnt_reg;
    logic [bfknn_pkg::PIDX_W-1:0]         p_cnt_next;
    logic [bfknn_pkg::DIDX_W-1:0]         d_cnt_reg;
    logic [bfknn_pkg::DIDX_W-1:0]         d_cnt_next;
    logic [bfknn_pkg::KIDX_W-1:0]         emit_cnt_reg;
    logic [bfknn_pkg::KIDX_W-1:0]         emit_cnt_next;
    logic [bfknn_pkg::COORD_W-1:0]        q_rdata;
    logic [bfknn_pkg::COORD_W-1:0]        ref_rdata;
    bfknn_pkg::issue_t                    issue_now;
    bfknn_pkg::issue_t                    issue_reg;
    bfknn_pkg::dist_t                     dres;
    logic                                 dbusy;
    logic [bfknn_pkg::PIDX_W-1:0]         in_pidx;
    logic [bfknn_pkg::DIDX_W-1:0]         in_didx;
    logic [bfknn_pkg::COORD_W-1:0]        in_coord;
    logic                                 in_acc;
    logic                                 ref_we;
    logic                                 q_we;
    logic                                 start;
    logic                                 last_dim;
    logic                                 last_pt;
    logic                                 emit_last;
    logic                                 clear;
    logic [bfknn_pkg::PIDX_W-1:0]         rd_point;
    logic [bfknn_pkg::DIST_W-1:0]         rd_dist;
    logic [bfknn_pkg::KIDX_W:0]           filled;

    assign in_pidx  = s_tdata[bfknn_pkg::PIDX_W-1:0];
    assign in_didx  = s_tdata[bfknn_pkg::PIDX_W +: bfknn_pkg::DIDX_W];
    assign in_coord = s_tdata[bfknn_pkg::PIDX_W + bfknn_pkg::DIDX_W +: bfknn_pkg::COORD_W];
    assign in_acc   = s_tvalid && s_tready;
    assign ref_we   = in_acc && !s_tuser;
    assign q_we     = in_acc && s_tuser;
    assign start    = q_we && ((bfknn_pkg::NDIM_W'(in_didx) + 1'b1) == m_eff);

    // Out-of-range register values saturate into their legal ranges.
    always_comb
    begin
        if (npts_reg == '0)
            n_eff = bfknn_pkg::NPTS_W'(1);
        else if (npts_reg > bfknn_pkg::NPTS_W'(bfknn_pkg::MAX_POINTS))
            n_eff = bfknn_pkg::NPTS_W'(bfknn_pkg::MAX_POINTS);
        else
            n_eff = npts_reg;
        if (ndim_reg == '0)
            m_eff = bfknn_pkg::NDIM_W'(1);
        else if (ndim_reg > bfknn_pkg::NDIM_W'(bfknn_pkg::MAX_DIMS))
            m_eff = bfknn_pkg::NDIM_W'(bfknn_pkg::MAX_DIMS);
        else
            m_eff = ndim_reg;
        if (nk_reg == '0)
            k_eff = bfknn_pkg::NK_W'(1);
        else if (nk_reg > bfknn_pkg::NK_W'(bfknn_pkg::MAX_K))
            k_eff = bfknn_pkg::NK_W'(bfknn_pkg::MAX_K);
        else
            k_eff = nk_reg;
        if (bfknn_pkg::NPTS_W'(k_eff) > n_eff)
            k_eff = bfknn_pkg::NK_W'(n_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg <= bfknn_pkg::NPTS_W'(bfknn_pkg::MAX_POINTS);
            ndim_reg <= bfknn_pkg::NDIM_W'(bfknn_pkg::MAX_DIMS);
            nk_reg   <= bfknn_pkg::NK_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bfknn_pkg::REG_NUM_POINTS:    npts_reg <= cfg_wdata;
                bfknn_pkg::REG_NUM_DIMS:      ndim_reg <= cfg_wdata[bfknn_pkg::NDIM_W-1:0];
                bfknn_pkg::REG_NUM_NEIGHBORS: nk_reg   <= cfg_wdata[bfknn_pkg::NK_W-1:0];
                default:                      ;
            endcase
        end
    end

    assign last_dim  = (bfknn_pkg::NDIM_W'(d_cnt_reg) + 1'b1) == m_eff;
    assign last_pt   = (bfknn_pkg::NPTS_W'(p_cnt_reg) + 1'b1) == n_eff;
    assign emit_last = ((bfknn_pkg::KIDX_W+1)'(emit_cnt_reg) + 1'b1) == filled;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfknn_pkg::ST_IDLE:
                if (start)
                    state_next = bfknn_pkg::ST_SCAN;
            bfknn_pkg::ST_SCAN:
                if (last_dim && last_pt)
                    state_next = bfknn_pkg::ST_DRAIN;
            bfknn_pkg::ST_DRAIN:
                if (!dbusy && !dres.valid)
                    state_next = bfknn_pkg::ST_EMIT;
            bfknn_pkg::ST_EMIT:
                if (m_tready && emit_last)
                    state_next = bfknn_pkg::ST_IDLE;
            default:
                state_next = bfknn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        clear         = 1'b0;
        issue_now     = '0;
        p_cnt_next    = p_cnt_reg;
        d_cnt_next    = d_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        unique case (state_reg)
            bfknn_pkg::ST_IDLE:
            begin
                s_tready      = 1'b1;
                clear         = start;
                p_cnt_next    = '0;
                d_cnt_next    = '0;
                emit_cnt_next = '0;
            end
            bfknn_pkg::ST_SCAN:
            begin
                issue_now.valid = 1'b1;
                issue_now.first = d_cnt_reg == '0;
                issue_now.last  = last_dim;
                issue_now.point = p_cnt_reg;
                if (last_dim)
                begin
                    d_cnt_next = '0;
                    p_cnt_next = p_cnt_reg + 1'b1;
                end
                else
                begin
                    d_cnt_next = d_cnt_reg + 1'b1;
                end
            end
            bfknn_pkg::ST_DRAIN:
                ;
            bfknn_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    emit_cnt_next = emit_cnt_reg + 1'b1;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfknn_pkg::ST_IDLE;
            p_cnt_reg    <= '0;
            d_cnt_reg    <= '0;
            emit_cnt_reg <= '0;
            issue_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p_cnt_reg    <= p_cnt_next;
            d_cnt_reg    <= d_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            issue_reg    <= issue_now;
        end
    end

    bfknn_ram #(
        .WIDTH (bfknn_pkg::COORD_W),
        .DEPTH (bfknn_pkg::MAX_DIMS)
    ) u_qbuf (
        .clk   (clk),
        .we    (q_we),
        .waddr (in_didx),
        .wdata (in_coord),
        .raddr (d_cnt_reg),
        .rdata (q_rdata)
    );

    bfknn_ram #(
        .WIDTH (bfknn_pkg::COORD_W),
        .DEPTH (bfknn_pkg::MAX_POINTS * bfknn_pkg::MAX_DIMS)
    ) u_store (
        .clk   (clk),
        .we    (ref_we),
        .waddr ({in_pidx, in_didx}),
        .wdata (in_coord),
        .raddr ({p_cnt_reg, d_cnt_reg}),
        .rdata (ref_rdata)
    );

    bfknn_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue_reg),
        .query_value (q_rdata),
        .ref_value   (ref_rdata),
        .result      (dres),
        .busy        (dbusy)
    );

    bfknn_sort u_sort (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .k_eff    (k_eff),
        .cand     (dres),
        .rd_idx   (emit_cnt_reg),
        .rd_point (rd_point),
        .rd_dist  (rd_dist),
        .filled   (filled)
    );

    assign m_tdata = {4'b0, rd_dist, rd_point, emit_cnt_reg};
    assign m_tlast = emit_last;

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> filled != '0)
        else $error("result presented from an empty list");
    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dres.valid |-> (state_reg == bfknn_pkg::ST_SCAN || state_reg == bfknn_pkg::ST_DRAIN))
        else $error("distance result outside a scan");
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after final result");
    a_no_input_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        issue_now.valid |-> !s_tready)
        else $error("input open during scan");

endmodule
